// ===== rtl/core/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// State space step guard package
// Shared sizes, store offsets, command codes and controller interface types.
// ----------------------------------------------------------------------------
package ssg_pkg;

  localparam int NumStates  = 4;
  localparam int NumInputs  = 2;
  localparam int NumOutputs = 2;
  localparam int NumGuards  = 4;
  localparam int FracBits   = 16;

  localparam int StoreDepth = 64;
  localparam int AddrW      = 6;
  localparam int OfsA  = 0;
  localparam int OfsB  = OfsA + NumStates * NumStates;
  localparam int OfsC  = OfsB + NumStates * NumInputs;
  localparam int OfsD  = OfsC + NumOutputs * NumStates;
  localparam int OfsH  = OfsD + NumOutputs * NumInputs;
  localparam int OfsBv = OfsH + NumGuards * NumStates;
  localparam int OfsU  = OfsBv + NumGuards;
  localparam int OfsX0 = OfsU + NumInputs;

  localparam logic [15:0] StepLimitReset = 16'd1000;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_RESTART = 2'd1,
    CMD_STEP    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_STEPPED = 2'd0,
    ST_CROSSED = 2'd1,
    ST_REFUSED = 2'd2
  } status_e;

  // Which operand the multiplier's second input takes.
  typedef enum logic [1:0] {
    OPB_X   = 2'd0,
    OPB_U   = 2'd1,
    OPB_ONE = 2'd2
  } opb_e;

  // Destination of a finished dot product.
  typedef enum logic [1:0] {
    DST_Y = 2'd0,
    DST_X = 2'd1,
    DST_G = 2'd2
  } dst_e;

  typedef struct packed {
    logic             rd_en;
    logic [AddrW:0]   rd_addr;
    logic             acc_clr;
    logic             mac_en;
    opb_e             opb;
    logic [3:0]       opb_idx;
    logic             acc_neg;
    logic             commit;
    dst_e             dst;
    logic [3:0]       dst_idx;
    logic             x_update;
    logic             load_x0;
  } dp_cmd_t;

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sh0_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -34'sh0_8000_0000) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

// ===== rtl/core/ssg_datapath.sv =====
// ----------------------------------------------------------------------------
// State space step guard datapath
// Coefficient store, shared multiply-accumulate unit, state and result registers.
// ----------------------------------------------------------------------------
module ssg_datapath (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [5:0]            wr_addr_i,
  input  logic signed [31:0]    wr_data_i,
  input  ssg_pkg::dp_cmd_t      cmd_i,
  output logic [3:0]            gnow_o,
  output logic signed [31:0]    x_o [ssg_pkg::NumStates],
  output logic signed [31:0]    y_o [ssg_pkg::NumOutputs]
);
  import ssg_pkg::*;

  logic signed [31:0] mem [StoreDepth];
  logic signed [31:0] rdata_q;
  logic               rvalid_q;
  logic               oob_q;
  logic               ld_q;
  logic signed [31:0] x_q [NumStates];
  logic signed [31:0] nx_q [NumStates];
  logic signed [31:0] y_q [NumOutputs];
  logic [NumGuards-1:0] g_q;
  logic signed [31:0] acc_q, acc_d;
  logic signed [31:0] opb;
  logic signed [63:0] prod_q;
  logic               prod_v_q, neg_q, commit_q, clr_q;
  opb_e               opb_q;
  logic [3:0]         opbi_q;
  dst_e               dst_q, dst_q2;
  logic [3:0]         dsti_q, dsti_q2;
  logic               commit_q2;
  logic signed [31:0] u_q [NumInputs];
  logic signed [31:0] rd_val;
  logic signed [31:0] sum;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (cmd_i.rd_en) begin
      rdata_q <= mem[cmd_i.rd_addr[AddrW-1:0]];
    end
  end

  // Stage 1: store read; stage 2: multiply; stage 3: accumulate.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvalid_q  <= 1'b0;
      prod_v_q  <= 1'b0;
      ld_q      <= 1'b0;
      commit_q  <= 1'b0;
      commit_q2 <= 1'b0;
      clr_q     <= 1'b0;
      neg_q     <= 1'b0;
      oob_q     <= 1'b0;
      opb_q     <= OPB_X;
      opbi_q    <= '0;
      dst_q     <= DST_Y;
      dst_q2    <= DST_Y;
      dsti_q    <= '0;
      dsti_q2   <= '0;
    end else begin
      rvalid_q  <= cmd_i.mac_en;
      ld_q      <= cmd_i.load_x0;
      oob_q     <= cmd_i.rd_addr[AddrW];
      opb_q     <= cmd_i.opb;
      opbi_q    <= cmd_i.opb_idx;
      neg_q     <= cmd_i.acc_neg;
      clr_q     <= cmd_i.acc_clr;
      commit_q  <= cmd_i.commit;
      dst_q     <= cmd_i.dst;
      dsti_q    <= cmd_i.dst_idx;
      prod_v_q  <= rvalid_q;
      commit_q2 <= commit_q;
      dst_q2    <= dst_q;
      dsti_q2   <= dsti_q;
    end
  end

  assign rd_val = oob_q ? 32'sd0 : rdata_q;

  always_comb begin
    case (opb_q)
      OPB_X:   opb = x_q[opbi_q[1:0]];
      OPB_U:   opb = u_q[opbi_q[0]];
      OPB_ONE: opb = 32'sd1 <<< FracBits;
      default: opb = 32'sd0;
    endcase
  end

  logic neg_q2, clr_q2;
  always_ff @(posedge clk_i) begin
    prod_q <= rd_val * opb;
    neg_q2 <= neg_q;
    clr_q2 <= clr_q;
  end

  // Arithmetic shift floors toward minus infinity; the result fits 48 bits,
  // so the saturating add works on the 34-bit sign-clipped value.
  logic signed [63:0] shp;
  logic signed [33:0] shc;
  assign shp = prod_q >>> FracBits;
  always_comb begin
    if (shp > 64'sh0000_0000_FFFF_FFFF) begin
      shc = 34'sh0_FFFF_FFFF;
    end else if (shp < -64'sh0000_0001_0000_0000) begin
      shc = -34'sh1_0000_0000;
    end else begin
      shc = shp[33:0];
    end
  end

  logic signed [31:0] base;
  assign base = clr_q2 ? 32'sd0 : acc_q;
  always_comb begin
    if (neg_q2) begin
      sum = sat32(34'(base) - shc);
    end else begin
      sum = sat32(34'(base) + shc);
    end
    acc_d = prod_v_q ? sum : acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      g_q   <= '0;
      for (int i = 0; i < NumStates; i++) begin
        x_q[i]  <= '0;
        nx_q[i] <= '0;
      end
      for (int i = 0; i < NumOutputs; i++) begin
        y_q[i] <= '0;
      end
    end else begin
      acc_q <= acc_d;
      if (commit_q2) begin
        case (dst_q2)
          DST_Y:   y_q[dsti_q2[0]] <= acc_d;
          DST_X:   nx_q[dsti_q2[1:0]] <= acc_d;
          DST_G:   g_q[dsti_q2[1:0]] <= acc_d[31];
          default: ;
        endcase
      end
      if (cmd_i.x_update) begin
        for (int i = 0; i < NumStates; i++) begin
          x_q[i] <= nx_q[i];
        end
      end
      if (ld_q) begin
        x_q[dsti_q[1:0]] <= rd_val;
      end
    end
  end

  // The input vector u is fetched at the start of each step.
  always_ff @(posedge clk_i) begin
    if (!ld_q && rvalid_q && clr_q == 1'b0 && opb_q == OPB_ONE
        && dst_q == DST_Y && neg_q == 1'b0 && opbi_q[3]) begin
      u_q[opbi_q[0]] <= rd_val;
    end
  end

  assign gnow_o = g_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
endmodule

// ===== rtl/core/ssg_ctrl.sv =====
// ----------------------------------------------------------------------------
// State space step guard controller
// Sequences restarts, dot products and result delivery over the shared MAC.
// ----------------------------------------------------------------------------
module ssg_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd_i,
  input  logic [15:0]        step_limit_i,
  input  logic [3:0]         gnow_i,
  output ssg_pkg::dp_cmd_t   dp_o,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         elem_o,
  output logic [3:0]         mask_o,
  output logic [1:0]         status_o,
  output logic               last_o,
  output logic               refused_o
);
  import ssg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOADX = 7'b0000010,
    S_LOADU = 7'b0000100,
    S_ISSUE = 7'b0001000,
    S_DRAIN = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [3:0]  row_q, row_d;
  logic [3:0]  col_q, col_d;
  logic [1:0]  ph_q, ph_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [3:0]  prev_q, prev_d;
  logic [15:0] steps_q, steps_d;
  logic        stop_q, stop_d;
  logic [3:0]  mask_q, mask_d;
  logic        ref_q, ref_d;
  logic [1:0]  elem_q, elem_d;
  logic [3:0]  rows;
  logic [3:0]  ncols;
  logic        ac;
  logic [3:0]  newly;

  assign ac = in_valid && in_ready;

  always_comb begin
    case (ph_q)
      2'd0:    rows = 4'(NumOutputs);
      2'd1:    rows = 4'(NumStates);
      default: rows = 4'(NumGuards);
    endcase
    // Guard rows use NumStates products plus the threshold subtraction.
    ncols = 4'(NumStates + ((ph_q == 2'd2) ? 1 : NumInputs));
  end

  assign newly = gnow_i & ~prev_q;

  always_comb begin
    state_d = state_q;
    row_d = row_q; col_d = col_q; ph_d = ph_q; cnt_d = cnt_q;
    prev_d = prev_q; steps_d = steps_q; stop_d = stop_q;
    mask_d = mask_q; ref_d = ref_q; elem_d = elem_q;
    dp_o = '0;
    dp_o.opb = OPB_X;
    dp_o.dst = DST_Y;
    in_ready = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready = 1'b1;
        if (ac) begin
          case (cmd_e'(cmd_i))
            CMD_RESTART: begin
              steps_d = '0; prev_d = '0; stop_d = 1'b0;
              row_d = '0; state_d = S_LOADX;
            end
            CMD_STEP: begin
              if (stop_q || steps_q >= step_limit_i) begin
                stop_d = 1'b1; ref_d = 1'b1; mask_d = '0; elem_d = '0;
                state_d = S_OUT;
              end else begin
                ref_d = 1'b0; row_d = '0; state_d = S_LOADU;
              end
            end
            default: ;
          endcase
        end
      end
      S_LOADX: begin
        dp_o.rd_en = 1'b1;
        dp_o.mac_en = 1'b0;
        dp_o.rd_addr = 7'(OfsX0) + 7'(row_q);
        dp_o.load_x0 = 1'b1;
        dp_o.dst_idx = row_q;
        row_d = row_q + 4'd1;
        if (row_q == 4'(NumStates - 1)) begin
          cnt_d = '0; state_d = S_DRAIN; ph_d = 2'd3;
        end
      end
      S_LOADU: begin
        // Fetch u through the read stage; the datapath latches it by its tag.
        dp_o.rd_en = 1'b1;
        dp_o.mac_en = 1'b1;
        dp_o.rd_addr = 7'(OfsU) + 7'(row_q);
        dp_o.opb = OPB_ONE;
        dp_o.opb_idx = {1'b1, 3'(row_q)};
        row_d = row_q + 4'd1;
        if (row_q == 4'(NumInputs - 1)) begin
          row_d = '0; col_d = '0; ph_d = 2'd0; cnt_d = '0;
          state_d = S_ISSUE;
        end
      end
      S_ISSUE: begin
        dp_o.rd_en = 1'b1;
        dp_o.mac_en = 1'b1;
        dp_o.acc_clr = (col_q == '0);
        dp_o.dst_idx = row_q;
        if (col_q < 4'(NumStates)) begin
          dp_o.opb = OPB_X;
          dp_o.opb_idx = col_q;
          case (ph_q)
            2'd0:    dp_o.rd_addr = 7'(OfsC + 0) + 7'(row_q) * 7'(NumStates) + 7'(col_q);
            2'd1:    dp_o.rd_addr = 7'(OfsA) + 7'(row_q) * 7'(NumStates) + 7'(col_q);
            default: dp_o.rd_addr = 7'(OfsH) + 7'(row_q) * 7'(NumStates) + 7'(col_q);
          endcase
        end else if (ph_q == 2'd2) begin
          dp_o.opb = OPB_ONE;
          dp_o.acc_neg = 1'b1;
          dp_o.rd_addr = 7'(OfsBv) + 7'(row_q);
        end else begin
          dp_o.opb = OPB_U;
          dp_o.opb_idx = col_q - 4'(NumStates);
          if (ph_q == 2'd0) begin
            dp_o.rd_addr = 7'(OfsD) + 7'(row_q) * 7'(NumInputs)
                         + 7'(col_q - 4'(NumStates));
          end else begin
            dp_o.rd_addr = 7'(OfsB) + 7'(row_q) * 7'(NumInputs)
                         + 7'(col_q - 4'(NumStates));
          end
        end
        col_d = col_q + 4'd1;
        if (col_q == ncols - 4'd1) begin
          dp_o.commit = 1'b1;
          case (ph_q)
            2'd0:    dp_o.dst = DST_Y;
            2'd1:    dp_o.dst = DST_X;
            default: dp_o.dst = DST_G;
          endcase
          col_d = '0;
          row_d = row_q + 4'd1;
          if (row_q == rows - 4'd1) begin
            cnt_d = '0; state_d = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd3) begin
          cnt_d = '0;
          row_d = '0; col_d = '0;
          case (ph_q)
            2'd3: state_d = S_IDLE;
            2'd2: state_d = S_FIN;
            2'd1: begin
              // The new state is in place before the guard rows start.
              dp_o.x_update = 1'b1; ph_d = 2'd2; state_d = S_ISSUE;
            end
            default: begin
              ph_d = 2'd1; state_d = S_ISSUE;
            end
          endcase
        end
      end
      S_FIN: begin
        mask_d = newly;
        prev_d = gnow_i;
        steps_d = steps_q + 16'd1;
        if (newly != '0 || (steps_q + 16'd1) >= step_limit_i) begin
          stop_d = 1'b1;
        end
        elem_d = '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (ref_q || elem_q == 2'(NumStates - 1)) begin
            state_d = S_IDLE;
          end else begin
            elem_d = elem_q + 2'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      row_q <= '0; col_q <= '0; ph_q <= '0; cnt_q <= '0;
      prev_q <= '0; steps_q <= '0; stop_q <= 1'b0;
      mask_q <= '0; ref_q <= 1'b0; elem_q <= '0;
    end else begin
      state_q <= state_d;
      row_q <= row_d; col_q <= col_d; ph_q <= ph_d; cnt_q <= cnt_d;
      prev_q <= prev_d; steps_q <= steps_d; stop_q <= stop_d;
      mask_q <= mask_d; ref_q <= ref_d; elem_q <= elem_d;
    end
  end

  assign out_valid = (state_q == S_OUT);
  assign elem_o    = ref_q ? 2'd0 : elem_q;
  assign mask_o    = ref_q ? 4'd0 : mask_q;
  assign status_o  = ref_q ? ST_REFUSED : ((mask_q != '0) ? ST_CROSSED : ST_STEPPED);
  assign last_o    = ref_q || (elem_q == 2'(NumStates - 1));
  assign refused_o = ref_q;
endmodule

// ===== rtl/core/state_space_step_guard_unit.sv =====
// A step fetches both inputs u, issues the output, state and guard dot products and
// drains the MAC after each group, then records new guard crossings; its results
// are offered one per cycle while out_ready is high, four in all; a refused step
// offers its single result on the next cycle. The unit takes one command at a time.
// Reset: asynchronous, active low; state, guards, step count and flags clear,
// step_limit returns to 1000, the store is undefined.
// ----------------------------------------------------------------------------
// State space step guard unit
// Top level joining the controller, the datapath and the step_limit register.
// ----------------------------------------------------------------------------
module state_space_step_guard_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd_i,
  input  logic [5:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         elem_index_o,
  output logic signed [31:0] state_value_o,
  output logic signed [31:0] output_value_o,
  output logic [3:0]         guard_mask_o,
  output logic [1:0]         status_o,
  output logic               last_o
);
  import ssg_pkg::*;

  logic [15:0]        limit_q;
  dp_cmd_t            dp;
  logic [3:0]         gnow;
  logic signed [31:0] xv [NumStates];
  logic signed [31:0] yv [NumOutputs];
  logic               refused;
  logic               wr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= StepLimitReset;
    end else if (cfg_we) begin
      limit_q <= cfg_wdata;
    end
  end

  assign wr = in_valid && in_ready && (cmd_i == CMD_WRITE);

  ssg_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_ready, .cmd_i,
    .step_limit_i(limit_q), .gnow_i(gnow), .dp_o(dp),
    .out_valid, .out_ready, .elem_o(elem_index_o), .mask_o(guard_mask_o),
    .status_o, .last_o, .refused_o(refused)
  );

  ssg_datapath u_dp (
    .clk_i, .rst_ni, .wr_en_i(wr), .wr_addr_i(coef_index_i),
    .wr_data_i(coef_value_i), .cmd_i(dp), .gnow_o(gnow), .x_o(xv), .y_o(yv)
  );

  assign state_value_o  = refused ? 32'sd0 : xv[elem_index_o];
  assign output_value_o = (refused || elem_index_o >= 2'(NumOutputs)) ? 32'sd0
                        : yv[elem_index_o[0]];
endmodule

// ===== rtl/core/ssg_checker.sv =====
// ----------------------------------------------------------------------------
// State space step guard checker
// Port-level properties of the top level, attached by bind.
// ----------------------------------------------------------------------------
module ssg_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] status_o,
  input logic [3:0] guard_mask_o,
  input logic       last_o,
  input logic [1:0] elem_index_o
);
  import ssg_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> !in_ready) else $error("input taken during delivery");
  a_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o == ST_CROSSED |-> guard_mask_o != 4'd0)
    else $error("bad crossing");
  a_refuse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && status_o == ST_REFUSED |-> last_o && elem_index_o == 2'd0)
    else $error("bad refusal");
endmodule

bind state_space_step_guard_unit ssg_checker u_ssg_checker (.*);

// ===== tb/sv/state_space_step_guard_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// State space step guard unit testbench
// Loads coefficients, restarts and steps the system under varied step limits,
// with random gaps on both channels. A directed table checks the stopping
// behaviour and refusals, and a built-in fixed point predictor checks every
// result that the unit returns.
// ----------------------------------------------------------------------------
module state_space_step_guard_unit_tb;
  import ssg_pkg::*;

  typedef struct packed {
    logic [1:0]         elem;
    logic signed [31:0] xval;
    logic signed [31:0] yval;
    logic [3:0]         gmask;
    logic [1:0]         stat;
    logic               fin;
  } step_res_t;

  typedef struct {
    cmd_e               cmd;
    logic [5:0]         idx;
    logic signed [31:0] val;
    logic               chk;
    status_e            want;
  } row_t;

  logic clk_i, rst_ni;
  logic in_valid, in_ready, cfg_we, out_valid, out_ready;
  logic [1:0] cmd_i;
  logic [5:0] coef_index_i;
  logic signed [31:0] coef_value_i;
  logic [15:0] cfg_wdata;
  logic [1:0] elem_index_o, status_o;
  logic signed [31:0] state_value_o, output_value_o;
  logic [3:0] guard_mask_o;
  logic last_o;

  state_space_step_guard_unit u_dut (
    .clk_i, .rst_ni, .in_valid, .in_ready, .cmd_i, .coef_index_i, .coef_value_i,
    .cfg_we, .cfg_wdata, .out_valid, .out_ready, .elem_index_o, .state_value_o,
    .output_value_o, .guard_mask_o, .status_o, .last_o
  );

  logic signed [31:0] coefs [StoreDepth];
  logic signed [31:0] xs [NumStates];
  logic [3:0] prev_g;
  logic [15:0] nsteps, limit;
  logic halted;
  step_res_t expected_q[$];
  status_e table_want_q[$];
  int errors, idle_cnt, send_idle, recv_stall, hold_cycles;
  bit hold_req;

  function automatic logic signed [31:0] sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmac(input logic signed [31:0] acc,
                                              input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    longint p;
    p = longint'(a) * longint'(b);
    return sat(longint'(acc) + (p >>> FracBits));
  endfunction

  task automatic predict_cmd(input cmd_e c, input logic [5:0] idx,
                             input logic signed [31:0] v);
    logic signed [31:0] y [NumOutputs];
    logic signed [31:0] nx [NumStates];
    logic signed [31:0] acc;
    logic [3:0] gnow, newly;
    step_res_t r;
    if (c == CMD_WRITE) begin
      coefs[idx] = v;
    end else if (c == CMD_RESTART) begin
      for (int i = 0; i < NumStates; i++) xs[i] = coefs[OfsX0 + i];
      nsteps = 0; prev_g = 0; halted = 0;
    end else if (c == CMD_STEP) begin
      if (halted || nsteps >= limit) begin
        halted = 1;
        r = '0; r.stat = ST_REFUSED; r.fin = 1;
        expected_q.push_back(r);
      end else begin
        for (int i = 0; i < NumOutputs; i++) begin
          acc = 0;
          for (int j = 0; j < NumStates; j++) acc = qmac(acc, coefs[OfsC+i*NumStates+j], xs[j]);
          for (int j = 0; j < NumInputs; j++) acc = qmac(acc, coefs[OfsD+i*NumInputs+j], coefs[OfsU+j]);
          y[i] = acc;
        end
        for (int i = 0; i < NumStates; i++) begin
          acc = 0;
          for (int j = 0; j < NumStates; j++) acc = qmac(acc, coefs[OfsA+i*NumStates+j], xs[j]);
          for (int j = 0; j < NumInputs; j++) acc = qmac(acc, coefs[OfsB+i*NumInputs+j], coefs[OfsU+j]);
          nx[i] = acc;
        end
        for (int i = 0; i < NumStates; i++) xs[i] = nx[i];
        gnow = 0;
        for (int g = 0; g < NumGuards; g++) begin
          acc = 0;
          for (int j = 0; j < NumStates; j++) acc = qmac(acc, coefs[OfsH+g*NumStates+j], xs[j]);
          acc = sat(longint'(acc) - longint'(coefs[OfsBv + g]));
          gnow[g] = acc < 0;
        end
        newly = gnow & ~prev_g;
        prev_g = gnow;
        nsteps = nsteps + 16'd1;
        if (newly != 0 || nsteps >= limit) halted = 1;
        for (int i = 0; i < NumStates; i++) begin
          r.elem = 2'(i); r.xval = xs[i];
          r.yval = (i < NumOutputs) ? y[i] : 32'sd0;
          r.gmask = newly; r.stat = (newly != 0) ? ST_CROSSED : ST_STEPPED;
          r.fin = (i == NumStates - 1);
          expected_q.push_back(r);
        end
      end
    end
  endtask

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cnt <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt > 20000) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    step_res_t got, exp_r;
    if (hold_req && hold_cycles == 0) hold_cycles <= 600;
    else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
    if (rst_ni && out_valid && out_ready) begin
      got = {elem_index_o, state_value_o, output_value_o, guard_mask_o, status_o, last_o};
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch expected %p actual %p", $time, exp_r, got);
          errors++;
        end
        if (exp_r.fin && table_want_q.size() > 0 && got.stat !== table_want_q[0]) begin
          $display("%0t: status expected %0d actual %0d", $time, table_want_q[0], got.stat);
          errors++;
        end
        if (exp_r.fin && table_want_q.size() > 0) void'(table_want_q.pop_front());
      end
    end
    if (hold_cycles > 1 || (hold_req && hold_cycles == 0)) out_ready <= 0;
    else out_ready <= ($urandom_range(99) >= recv_stall);
  end

  task automatic send(input cmd_e c, input logic [5:0] idx, input logic signed [31:0] v);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
    in_valid <= 1; cmd_i <= c; coef_index_i <= idx; coef_value_i <= v;
    do @(posedge clk_i); while (!in_ready);
    predict_cmd(c, idx, v);
  endtask

  task automatic set_limit(input logic [15:0] v);
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    cfg_we <= 1; cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 0;
    limit = v;
  endtask

  function automatic logic signed [31:0] small_coef();
    return $signed(32'($urandom_range(0, 32'h0002_0000))) - 32'sh0001_0000;
  endfunction

  initial begin
    row_t rows[$];
    row_t rw;
    rst_ni = 0; in_valid = 0; cmd_i = CMD_NONE; coef_index_i = 0; coef_value_i = 0;
    cfg_we = 0; cfg_wdata = 0; out_ready = 0; errors = 0; hold_req = 0;
    hold_cycles = 0; send_idle = 0; recv_stall = 0; limit = StepLimitReset;
    xs = '{default: 0}; prev_g = 0; nsteps = 0; halted = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // Zero store, then extreme words, then a step limit of two.
    for (int a = 0; a < StoreDepth; a++) send(CMD_WRITE, 6'(a), 0);
    rows.push_back('{CMD_NONE, 6'd63, 32'sh7FFF_FFFF, 0, ST_STEPPED});
    rows.push_back('{CMD_STEP, 6'd0, 0, 1, ST_STEPPED});
    rows.push_back('{CMD_WRITE, 6'(OfsA), 32'sh7FFF_FFFF, 0, ST_STEPPED});
    rows.push_back('{CMD_WRITE, 6'(OfsA + 1), 32'sh8000_0000, 0, ST_STEPPED});
    rows.push_back('{CMD_WRITE, 6'(OfsX0), 32'sh7FFF_FFFF, 0, ST_STEPPED});
    rows.push_back('{CMD_WRITE, 6'(OfsX0 + 1), 32'sh8000_0000, 0, ST_STEPPED});
    rows.push_back('{CMD_WRITE, 6'(OfsC), 32'sh7FFF_FFFF, 0, ST_STEPPED});
    rows.push_back('{CMD_WRITE, 6'(OfsU), 32'sh8000_0000, 0, ST_STEPPED});
    rows.push_back('{CMD_WRITE, 6'(OfsB + 1), 32'sh7FFF_FFFF, 0, ST_STEPPED});
    rows.push_back('{CMD_RESTART, 6'd0, 0, 0, ST_STEPPED});
    rows.push_back('{CMD_STEP, 6'd0, 0, 1, ST_STEPPED});
    rows.push_back('{CMD_WRITE, 6'(OfsBv + 2), 32'sh0001_0000, 0, ST_STEPPED});
    rows.push_back('{CMD_STEP, 6'd0, 0, 1, ST_CROSSED});
    rows.push_back('{CMD_STEP, 6'd0, 0, 1, ST_REFUSED});
    rows.push_back('{CMD_WRITE, 6'(OfsBv + 2), 32'sh8000_0000, 0, ST_STEPPED});
    rows.push_back('{CMD_RESTART, 6'd0, 0, 0, ST_STEPPED});
    foreach (rows[k]) begin
      rw = rows[k];
      if (rw.chk) table_want_q.push_back(rw.want);
      send(rw.cmd, rw.idx, rw.val);
    end
    set_limit(16'd2);
    send(CMD_STEP, 0, 0); table_want_q.push_back(ST_STEPPED);
    send(CMD_STEP, 0, 0); table_want_q.push_back(ST_STEPPED);
    send(CMD_STEP, 0, 0); table_want_q.push_back(ST_REFUSED);
    set_limit(16'd0);
    send(CMD_RESTART, 0, 0);
    send(CMD_STEP, 0, 0); table_want_q.push_back(ST_REFUSED);

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 58; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 58; end
        3: begin send_idle = 13; recv_stall = 13; end
        default: begin send_idle = 0; recv_stall = 0; end
      endcase
      set_limit(ph == 4 ? 16'hFFFF : 16'($urandom_range(3, 12)));
      for (int k = 0; k < 6; k++)
        send(CMD_WRITE, 6'($urandom()), (ph == 3) ? $signed($urandom()) : small_coef());
      send(CMD_RESTART, 0, 0);
      if (ph == 2) hold_req = 1;
      for (int n = 0; n < 5; n++) begin
        int pick;
        pick = $urandom_range(99);
        if (n == 3) hold_req = 0;
        if (pick < 65) send(CMD_STEP, 6'($urandom()), $urandom());
        else if (pick < 80) send(CMD_WRITE, 6'($urandom()), small_coef());
        else if (pick < 92) send(CMD_RESTART, 6'($urandom()), $urandom());
        else send(CMD_NONE, 6'($urandom()), $urandom());
      end
    end
    in_valid <= 0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && table_want_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
